FILE: rtl/core/fbpa_pkg.sv
// fbpa_pkg: shared types and constants for the frame buffer pool allocator.
// No dependencies; imported by every module of the block.
package fbpa_pkg;

  localparam int CNT_W  = 3;
  localparam int OP_W   = 2;
  localparam int PAGE_W = 16;
  localparam int IDX_W  = 3;

  // request opcodes
  localparam logic [OP_W-1:0] OP_GET  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;   // reserved, does nothing

  // slot usage codes
  typedef logic [1:0] use_t;
  localparam use_t USE_FREE = 2'd0;
  localparam use_t USE_CUR  = 2'd1;
  localparam use_t USE_PREP = 2'd2;

  localparam logic [PAGE_W-1:0] PAGE_NONE = 16'hFFFF;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PAGE_W-1:0] page_id;
    logic              for_current;
    logic [IDX_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] granted_slot;
    logic             is_device_buffer;
    logic             picture_kept;
  } result_t;

endpackage

FILE: rtl/core/fbpa_req_stage.sv
// fbpa_req_stage: input register that captures one request per cycle.
// Depends on fbpa_pkg.
module fbpa_req_stage
  import fbpa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req_in,
  output logic req_valid,
  output req_t req
);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req <= req_in;
    end
  end

endmodule

FILE: rtl/core/fbpa_slot_pool.sv
// fbpa_slot_pool: per-slot state, parallel slot searches and state update.
// Depends on fbpa_pkg; fed by fbpa_req_stage.
module fbpa_slot_pool
  import fbpa_pkg::*;
#(
  parameter int POOL_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_count,
  input  logic             req_valid,
  input  req_t             req,
  output result_t          res
);

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [CNT_W-1:0] TOP_MAX =
    CNT_W'((POOL_SLOTS - 1 > 7) ? 7 : POOL_SLOTS - 1);

  logic [CNT_W-1:0]  count;
  use_t              slot_use   [POOL_SLOTS];
  logic              slot_drawn [POOL_SLOTS];
  logic [PAGE_W-1:0] slot_page  [POOL_SLOTS];

  logic [CNT_W-1:0]      top;
  logic [SLOT_W-1:0]     top_w;
  logic [SLOT_W-1:0]     idx_w;
  logic                  idx_ok;
  logic [POOL_SLOTS-1:0] active;
  logic [POOL_SLOTS-1:0] is_free;
  logic [POOL_SLOTS-1:0] m_page;
  logic [POOL_SLOTS-1:0] m_blank;
  logic [POOL_SLOTS-1:0] idx_hot;
  logic [POOL_SLOTS-1:0] sel_hot;
  logic [SLOT_W-1:0]     h_page, h_blank, h_free, sel;
  logic                  f_page, f_blank, f_free;
  logic                  get_ok;
  use_t                  mark_use;

  assign top      = (count > TOP_MAX) ? TOP_MAX : count;
  assign top_w    = SLOT_W'(top);
  assign idx_ok   = (req.slot_index <= top);
  assign idx_w    = SLOT_W'(req.slot_index);
  assign mark_use = req.for_current ? USE_CUR : USE_PREP;

  for (genvar k = 0; k < POOL_SLOTS; k++) begin : g_cmp
    assign active[k]  = (SLOT_W'(k) <= top_w);
    assign is_free[k] = active[k] && (slot_use[k] == USE_FREE);
    assign m_page[k]  = is_free[k] && (slot_page[k] == req.page_id);
    assign m_blank[k] = is_free[k] && !slot_drawn[k];
    assign idx_hot[k] = idx_ok && (idx_w == SLOT_W'(k));
    assign sel_hot[k] = (sel == SLOT_W'(k));
  end

  // highest matching slot wins
  always_comb begin
    h_page  = '0;
    h_blank = '0;
    h_free  = '0;
    f_page  = 1'b0;
    f_blank = 1'b0;
    f_free  = 1'b0;
    for (int k = 0; k < POOL_SLOTS; k++) begin
      if (m_page[k]) begin
        h_page = SLOT_W'(k);
        f_page = 1'b1;
      end
      if (m_blank[k]) begin
        h_blank = SLOT_W'(k);
        f_blank = 1'b1;
      end
      if (is_free[k]) begin
        h_free = SLOT_W'(k);
        f_free = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (f_page) begin
      sel = h_page;
    end else if (f_blank) begin
      sel = h_blank;
    end else if (f_free) begin
      sel = h_free;
    end else begin
      sel = top_w;
    end
  end

  assign get_ok = f_free || req.for_current;

  always_comb begin
    res = '0;
    unique case (req.opcode)
      OP_GET: begin
        if (get_ok) begin
          res.granted          = 1'b1;
          res.granted_slot     = IDX_W'(sel);
          res.is_device_buffer = (sel == '0);
          res.picture_kept     = f_page;
        end
      end
      OP_PUT, OP_MARK: begin
        res.granted          = idx_ok;
        res.granted_slot     = req.slot_index;
        res.is_device_buffer = idx_ok && (req.slot_index == '0);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      count <= rst ? '0 : cfg_count;
      for (int k = 0; k < POOL_SLOTS; k++) begin
        slot_use[k]   <= USE_FREE;
        slot_drawn[k] <= 1'b0;
        slot_page[k]  <= '0;
      end
      if (!rst && (cfg_count != '0)) begin
        slot_use[0] <= USE_CUR;
      end
    end else if (req_valid) begin
      for (int k = 0; k < POOL_SLOTS; k++) begin
        unique case (req.opcode)
          OP_GET: begin
            if (get_ok && sel_hot[k]) begin
              slot_use[k] <= mark_use;
              if (!f_page) begin
                slot_page[k]  <= req.page_id;
                slot_drawn[k] <= 1'b0;
              end
            end
          end
          OP_PUT: begin
            if (idx_hot[k]) begin
              slot_use[k] <= USE_FREE;
              if (slot_page[k] == PAGE_NONE) begin
                slot_drawn[k] <= 1'b0;
              end
            end
          end
          OP_MARK: begin
            if (idx_hot[k]) begin
              slot_drawn[k] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/frame_buffer_pool_allocator_top.sv
// frame_buffer_pool_allocator_top: top level of the frame buffer pool allocator.
// Depends on fbpa_pkg, fbpa_req_stage and fbpa_slot_pool.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  request   | start / busy              | opcode, page_id, for_current,
//            |                           | slot_index
//  result    | done (one-cycle strobe)   | granted, granted_slot,
//            |                           | is_device_buffer, picture_kept
//  config    | cfg_valid / cfg_ready     | cfg_data (cache buffer count)
//
// A request is taken when start is high and busy is low; busy stays low, so a
// request can be taken every cycle. Each request gives its result through the
// input register, then slot search and state update into the result register,
// one result per cycle sustained; the slot search is the path.
// Synchronous reset empties the pipe and clears the pool with count zero.
// The result receiver cannot stall: done is a one-cycle strobe.
// cfg_ready drops while a request sits in the input register; a config write
// reinitializes the pool.
module frame_buffer_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int POOL_SLOTS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // request
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          opcode,
  input  logic signed [PAGE_W-1:0] page_id,
  input  logic                     for_current,
  input  logic [IDX_W-1:0]         slot_index,
  // result
  output logic                     done,
  output logic                     granted,
  output logic [IDX_W-1:0]         granted_slot,
  output logic                     is_device_buffer,
  output logic                     picture_kept,
  // config
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data
);

  req_t    req_in;
  req_t    req;
  logic    req_valid;
  logic    take;
  logic    cfg_write;
  result_t res;
  result_t res_q;

  // never stalls the requester
  assign busy = 1'b0;
  assign take = start && !busy;

  assign req_in.opcode      = opcode;
  assign req_in.page_id     = page_id;
  assign req_in.for_current = for_current;
  assign req_in.slot_index  = slot_index;

  // hold off config while a request is still to be applied to the pool
  assign cfg_ready = !req_valid;
  assign cfg_write = cfg_valid && cfg_ready;

  fbpa_req_stage u_req_stage (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req_in    (req_in),
    .req_valid (req_valid),
    .req       (req)
  );

  fbpa_slot_pool #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_slot_pool (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_count (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      res_q <= res;
    end
  end

  assign granted          = res_q.granted;
  assign granted_slot     = res_q.granted_slot;
  assign is_device_buffer = res_q.is_device_buffer;
  assign picture_kept     = res_q.picture_kept;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for frame_buffer_pool_allocator_top.
// Depends on fbpa_pkg and the block's RTL; an internal pool tracker predicts
// every result and checks it against the block's output.
`timescale 1ns / 1ps

module tb_top;
  import fbpa_pkg::*;

  localparam int SLOTS      = 8;
  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake before giving up
  localparam int ITEMS_PER_PHASE = 180;

  // ---------------------------------------------------------------------------
  // Pool tracker: mirror of the slot pool plus a queue of predicted grants.
  // note_request applies one request to the mirror; check_grant compares one
  // result strobe with the oldest prediction.
  // ---------------------------------------------------------------------------
  class pool_tracker;
    int unsigned       top;
    use_t              slot_use   [SLOTS];
    bit                slot_drawn [SLOTS];
    logic [PAGE_W-1:0] slot_page  [SLOTS];
    result_t           pending_grants[$];
    int                errors;

    // A count write clears the pool; slot 0 is held for current unless count is 0.
    function void reinit(logic [CNT_W-1:0] count);
      top = (int'(count) > SLOTS - 1) ? SLOTS - 1 : int'(count);
      for (int k = 0; k < SLOTS; k++) begin
        slot_use[k]   = USE_FREE;
        slot_drawn[k] = 1'b0;
        slot_page[k]  = '0;
      end
      if (count != '0) slot_use[0] = USE_CUR;
    endfunction

    function void note_request(req_t rq);
      result_t r;
      use_t    tag;
      bit      found;
      r     = '0;
      found = 0;
      tag   = rq.for_current ? USE_CUR : USE_PREP;
      case (rq.opcode)
        OP_GET: begin
          // same page, free: picture kept
          for (int k = top; k >= 0; k--) begin
            if (!found && slot_use[k] == USE_FREE && slot_page[k] == rq.page_id) begin
              found = 1;
              slot_use[k] = tag;
              r.granted = 1'b1; r.granted_slot = IDX_W'(k); r.picture_kept = 1'b1;
            end
          end
          // free and blank
          for (int k = top; k >= 0; k--) begin
            if (!found && slot_use[k] == USE_FREE && !slot_drawn[k]) begin
              found = 1;
              slot_page[k] = rq.page_id;
              slot_use[k]  = tag;
              r.granted = 1'b1; r.granted_slot = IDX_W'(k);
            end
          end
          // any free slot, picture thrown away
          for (int k = top; k >= 0; k--) begin
            if (!found && slot_use[k] == USE_FREE) begin
              found = 1;
              slot_page[k]  = rq.page_id;
              slot_drawn[k] = 1'b0;
              slot_use[k]   = tag;
              r.granted = 1'b1; r.granted_slot = IDX_W'(k);
            end
          end
          // nothing free: current display takes the top slot by force
          if (!found && rq.for_current) begin
            slot_page[top]  = rq.page_id;
            slot_drawn[top] = 1'b0;
            slot_use[top]   = tag;
            r.granted = 1'b1; r.granted_slot = IDX_W'(top);
          end
        end
        OP_PUT, OP_MARK: begin
          r.granted_slot = rq.slot_index;
          if (rq.slot_index <= top) begin
            r.granted = 1'b1;
            if (rq.opcode == OP_PUT) begin
              slot_use[rq.slot_index] = USE_FREE;
              if (slot_page[rq.slot_index] == PAGE_NONE) slot_drawn[rq.slot_index] = 1'b0;
            end else begin
              slot_drawn[rq.slot_index] = 1'b1;
            end
          end
        end
        default: r = '0;
      endcase
      r.is_device_buffer = r.granted && (r.granted_slot == '0);
      pending_grants.push_back(r);
    endfunction

    function void check_grant(result_t got);
      result_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: result with no request pending: %p", $time, got);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.granted !== want.granted) begin
        $display("%0t: granted expected %0d actual %0d", $time, want.granted, got.granted);
        errors++;
      end
      if (got.granted_slot !== want.granted_slot) begin
        $display("%0t: granted_slot expected %0d actual %0d", $time,
                 want.granted_slot, got.granted_slot);
        errors++;
      end
      if (got.is_device_buffer !== want.is_device_buffer) begin
        $display("%0t: is_device_buffer expected %0d actual %0d", $time,
                 want.is_device_buffer, got.is_device_buffer);
        errors++;
      end
      if (got.picture_kept !== want.picture_kept) begin
        $display("%0t: picture_kept expected %0d actual %0d", $time,
                 want.picture_kept, got.picture_kept);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          opcode;
  logic signed [PAGE_W-1:0] page_id;
  logic                     for_current;
  logic [IDX_W-1:0]         slot_index;
  logic                     done;
  logic                     granted;
  logic [IDX_W-1:0]         granted_slot;
  logic                     is_device_buffer;
  logic                     picture_kept;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data;

  frame_buffer_pool_allocator_top #(
    .POOL_SLOTS(SLOTS)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .page_id         (page_id),
    .for_current     (for_current),
    .slot_index      (slot_index),
    .done            (done),
    .granted         (granted),
    .granted_slot    (granted_slot),
    .is_device_buffer(is_device_buffer),
    .picture_kept    (picture_kept),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  pool_tracker tracker = new();
  int unsigned idle_cycles;
  int unsigned live_count;    // count currently programmed, steers slot_index picks
  bit          no_gaps;       // back-to-back stretch, no idling

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor: done is a one-cycle strobe, sampled at the edge ending it.
  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_grant('{granted: granted, granted_slot: granted_slot,
                            is_device_buffer: is_device_buffer,
                            picture_kept: picture_kept});
  end

  // Watchdog: any request, result or count write resets the idle counter.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("frame_buffer_pool_allocator_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drive helpers
  // ---------------------------------------------------------------------------
  function automatic req_t mk(logic [OP_W-1:0] op, logic [PAGE_W-1:0] pg, logic cur,
                              logic [IDX_W-1:0] idx);
    req_t rq;
    rq.opcode      = op;
    rq.page_id     = pg;
    rq.for_current = cur;
    rq.slot_index  = idx;
    return rq;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random request. Pages come from a small pool so gets hit earlier puts;
  // slot_index mostly lands on active slots.
  function automatic req_t rand_req();
    req_t        rq;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      rq.opcode = OP_GET;
    else if (r < 80) rq.opcode = OP_PUT;
    else if (r < 97) rq.opcode = OP_MARK;
    else             rq.opcode = OP_RSVD;
    r = $urandom_range(0, 99);
    if (r < 60)      rq.page_id = PAGE_W'($urandom_range(0, 3));
    else if (r < 75) rq.page_id = PAGE_NONE;
    else             rq.page_id = PAGE_W'($urandom_range(0, 32767));
    rq.for_current = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) rq.slot_index = IDX_W'($urandom_range(0, live_count));
    else                            rq.slot_index = IDX_W'($urandom_range(0, SLOTS - 1));
    return rq;
  endfunction

  // Hold start with the request until it is taken. start is left high so a
  // following request goes out back to back.
  task automatic issue(req_t rq);
    start       <= 1'b1;
    opcode      <= rq.opcode;
    page_id     <= rq.page_id;
    for_current <= rq.for_current;
    slot_index  <= rq.slot_index;
    do @(posedge clk); while (busy);
    tracker.note_request(rq);
  endtask

  task automatic idle(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Count writes only with the pipe empty.
  task automatic write_count(logic [CNT_W-1:0] count);
    start <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data  <= CNT_W'($urandom_range(0, 7));
    tracker.reinit(count);
    live_count = int'(count);
  endtask

  task automatic send_all(req_t list[$]);
    foreach (list[i]) begin
      issue(list[i]);
      idle(gap_len());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    req_t            plan[$];
    logic [CNT_W-1:0] phase_counts[8];

    rst         <= 1'b1;
    start       <= 1'b0;
    opcode      <= OP_GET;
    page_id     <= '0;
    for_current <= 1'b0;
    slot_index  <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    no_gaps     = 0;
    live_count  = 0;
    tracker.reinit('0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, count 0 after reset: only the device buffer exists.
    plan = '{mk(OP_GET, 16'd0, 1'b0, 3'd0),       // page matches reset value, kept
             mk(OP_GET, 16'd5, 1'b0, 3'd7),       // nothing free, prepare fails
             mk(OP_GET, PAGE_NONE, 1'b1, 3'd2),   // forced take lands on slot 0
             mk(OP_MARK, 16'd0, 1'b0, 3'd0),
             mk(OP_PUT, 16'd0, 1'b1, 3'd0),       // page none: picture blanked
             mk(OP_PUT, 16'd9, 1'b0, 3'd3),       // slot above count ignored
             mk(OP_MARK, 16'd9, 1'b1, 3'd7),      // slot above count ignored
             mk(OP_RSVD, 16'h7FFF, 1'b1, 3'd5)};  // unused opcode
    send_all(plan);

    // Directed, count 1: drawn free slot reused, then forced take of slot 1.
    write_count(3'd1);
    plan = '{mk(OP_GET, 16'd9, 1'b0, 3'd0),
             mk(OP_MARK, 16'd0, 1'b0, 3'd1),
             mk(OP_PUT, 16'd0, 1'b0, 3'd1),       // freed but still drawn
             mk(OP_GET, 16'd10, 1'b1, 3'd0),      // drawn free slot, blanked
             mk(OP_GET, 16'd11, 1'b0, 3'd0),      // prepare fails
             mk(OP_GET, 16'd12, 1'b1, 3'd0)};     // forced take of top slot
    send_all(plan);

    // Directed, count 7: top page id, match with kept picture.
    write_count(3'd7);
    plan = '{mk(OP_GET, 16'h7FFF, 1'b0, 3'd0),
             mk(OP_MARK, 16'd0, 1'b0, 3'd7),
             mk(OP_PUT, 16'd0, 1'b0, 3'd7),
             mk(OP_GET, 16'h7FFF, 1'b1, 3'd0),    // same page: picture kept
             mk(OP_PUT, 16'd0, 1'b0, 3'd7),
             mk(OP_GET, PAGE_NONE, 1'b0, 3'd0),
             mk(OP_PUT, 16'd0, 1'b1, 3'd0)};
    send_all(plan);

    // Random phases over several counts, both extremes included.
    phase_counts = '{3'd7, 3'd0, 3'd1, 3'd3, 3'd7, 3'd2, 3'd5, 3'd0};
    phase_counts[5] = CNT_W'($urandom_range(0, 7));
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        issue(rand_req());
        // occasional back-to-back stretch inside a phase
        if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
        idle(gap_len());
      end
    end

    // Drain: every request gives one result.
    start <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.pending_grants.size() != 0) tracker.errors++;

    if (tracker.errors == 0)
      $display("frame_buffer_pool_allocator_top verification clean");
    else
      $display("frame_buffer_pool_allocator_top verification failed");
    $finish;
  end

endmodule
